// ===== src/rwsp_pkg.sv =====
// rwsp_pkg: parse phases, opcodes, result kinds, error codes and tag constants
// for the riff/wave stream parser; no dependencies
package rwsp_pkg;

	typedef enum logic [3:0] {
		PH_RIFF_TAG   = 4'd0,
		PH_RIFF_SIZE  = 4'd1,
		PH_WAVE_TAG   = 4'd2,
		PH_CHUNK_ID   = 4'd3,
		PH_CHUNK_SIZE = 4'd4,
		PH_FMT_BODY   = 4'd5,
		PH_SKIP       = 4'd6,
		PH_DATA       = 4'd7,
		PH_DONE       = 4'd8,
		PH_ERROR      = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		OP_BYTE     = 2'd0,
		OP_EOF      = 2'd1,
		OP_RESTART  = 2'd2,
		OP_RESERVED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_HEADER = 2'd0,
		K_AUDIO  = 2'd1,
		K_ERROR  = 2'd2,
		K_IGNORE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE      = 3'd0,
		E_BAD_TAG   = 3'd1,
		E_EOF_EARLY = 3'd2,
		E_NO_FMT    = 3'd3,
		E_NOT_PCM   = 3'd4,
		E_FMT_SHORT = 3'd5,
		E_TRUNCATED = 3'd6,
		E_SPARE     = 3'd7
	} err_t;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [15:0] PCM_CODE = 16'd1;
	localparam logic [31:0] FMT_LEN  = 32'd16;

	localparam int FMT_BYTES = 16;
	localparam int POS_W     = 4;

	// number of bytes in the fmt field that starts at this offset, 0 if none starts here
	function automatic logic [2:0] fmt_field_len(input logic [POS_W-1:0] off);
		logic [2:0] n;
		case (off)
			4'd0, 4'd2, 4'd12, 4'd14: n = 3'd2;
			4'd4, 4'd8:               n = 3'd4;
			default:                  n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== src/riff_wave_stream_parser.sv =====
// riff_wave_stream_parser: byte-wide wav header parser with audio pass-through
// latency: a request's result is valid on m_* in the cycle after it is accepted
// throughput: one file byte per cycle, set by the single parse register stage;
//   s_tready stays high while the output slot is empty or being taken
// reset: expecting the RIFF tag, no error held, captured fmt fields all zero
// depends on rwsp_pkg
module riff_wave_stream_parser
	import rwsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // byte_value[7:0]
	input  logic [1:0]   s_tuser,   // opcode[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// data_byte[7:0], error_code[10:8], format_tag[26:11], channel_count[42:27],
	// sample_rate[74:43], byte_rate[106:75], block_align[122:107],
	// sample_bits[138:123], format_seen[139], zero[143:140]
	output logic [143:0] m_tdata,
	output logic [1:0]   m_tuser,   // kind[1:0]
	output logic         m_tlast    // last_data
);

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [31:0]        tag_q, tag_d;
	logic [31:0]        len_q, len_d;
	logic [31:0]        rem_q, rem_d;
	logic               fmt_seen_q, fmt_seen_d;
	err_t               err_q, err_d;
	logic [8*FMT_BYTES-1:0] fmt_q, fmt_d;

	logic               m_tvalid_q;
	kind_t              kind_q, kind_d;
	logic [7:0]         byte_q, byte_d;
	logic               last_q, last_d;

	op_t                op;
	logic               accept;
	logic               active;
	logic               raise;
	err_t               raise_code;
	logic               pos_end4;
	logic [31:0]        tag_shift;
	logic [31:0]        len_shift;
	logic [31:0]        rem_dec;
	logic [2:0]         flen;

	assign op       = op_t'(s_tuser);
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign active    = (op == OP_BYTE || op == OP_EOF) && phase_q != PH_ERROR
		&& phase_q != PH_DONE;
	assign pos_end4  = (pos_q == POS_W'(3));
	assign tag_shift = {tag_q[23:0], s_tdata};
	assign len_shift = {s_tdata, len_q[31:8]};
	assign rem_dec   = rem_q - 32'd1;
	assign flen      = fmt_field_len(pos_q);

	// error detection, shared by next state and result
	always_comb begin
		raise      = 1'b0;
		raise_code = E_NONE;
		if (active) begin
			if (op == OP_EOF) begin
				raise = 1'b1;
				case (phase_q)
					PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG: raise_code = E_BAD_TAG;
					PH_DATA:                                raise_code = E_TRUNCATED;
					default:                                raise_code = E_EOF_EARLY;
				endcase
			end else begin
				case (phase_q)
					PH_RIFF_TAG: begin
						if (pos_end4 && tag_shift != TAG_RIFF) begin
							raise      = 1'b1;
							raise_code = E_BAD_TAG;
						end
					end
					PH_WAVE_TAG: begin
						if (pos_end4 && tag_shift != TAG_WAVE) begin
							raise      = 1'b1;
							raise_code = E_BAD_TAG;
						end
					end
					PH_CHUNK_SIZE: begin
						if (pos_end4) begin
							if (tag_q == TAG_FMT && len_shift < FMT_LEN) begin
								raise      = 1'b1;
								raise_code = E_FMT_SHORT;
							end else if (tag_q == TAG_DATA && !fmt_seen_q) begin
								raise      = 1'b1;
								raise_code = E_NO_FMT;
							end else if (tag_q == TAG_DATA && fmt_q[15:0] != PCM_CODE) begin
								raise      = 1'b1;
								raise_code = E_NOT_PCM;
							end
						end
					end
					default: begin
						raise      = 1'b0;
						raise_code = E_NONE;
					end
				endcase
			end
		end
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		tag_d      = tag_q;
		len_d      = len_q;
		rem_d      = rem_q;
		fmt_seen_d = fmt_seen_q;
		err_d      = err_q;
		fmt_d      = fmt_q;
		if (op == OP_RESTART) begin
			phase_d    = PH_RIFF_TAG;
			pos_d      = '0;
			tag_d      = '0;
			len_d      = '0;
			rem_d      = '0;
			fmt_seen_d = 1'b0;
			err_d      = E_NONE;
			fmt_d      = '0;
		end else if (raise) begin
			phase_d = PH_ERROR;
			err_d   = raise_code;
		end else if (active && op == OP_BYTE) begin
			case (phase_q)
				PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
					tag_d = tag_shift;
					pos_d = pos_end4 ? '0 : pos_q + POS_W'(1);
					if (pos_end4) begin
						case (phase_q)
							PH_RIFF_TAG: phase_d = PH_RIFF_SIZE;
							PH_WAVE_TAG: phase_d = PH_CHUNK_ID;
							default:     phase_d = PH_CHUNK_SIZE;
						endcase
					end
				end
				PH_RIFF_SIZE: begin
					pos_d = pos_end4 ? '0 : pos_q + POS_W'(1);
					if (pos_end4)
						phase_d = PH_WAVE_TAG;
				end
				PH_CHUNK_SIZE: begin
					len_d = len_shift;
					pos_d = pos_end4 ? '0 : pos_q + POS_W'(1);
					if (pos_end4) begin
						if (tag_q == TAG_FMT) begin
							rem_d   = len_shift - FMT_LEN;
							phase_d = PH_FMT_BODY;
						end else if (tag_q == TAG_DATA) begin
							rem_d   = len_shift;
							phase_d = (len_shift == '0) ? PH_DONE : PH_DATA;
						end else begin
							rem_d   = len_shift;
							phase_d = (len_shift == '0) ? PH_CHUNK_ID : PH_SKIP;
						end
					end
				end
				PH_FMT_BODY: begin
					// a field's first byte clears the rest of that field
					for (int i = 0; i < FMT_BYTES; i++) begin
						if (POS_W'(i) == pos_q)
							fmt_d[8*i +: 8] = s_tdata;
						else if (POS_W'(i) > pos_q && {1'b0, POS_W'(i)} < {1'b0, pos_q}
								+ (POS_W+1)'(flen))
							fmt_d[8*i +: 8] = 8'd0;
					end
					pos_d = pos_q + POS_W'(1);
					if (pos_q == POS_W'(FMT_BYTES - 1)) begin
						fmt_seen_d = 1'b1;
						phase_d    = (rem_q == '0) ? PH_CHUNK_ID : PH_SKIP;
					end
				end
				PH_SKIP: begin
					rem_d = rem_dec;
					if (rem_dec == '0)
						phase_d = PH_CHUNK_ID;
				end
				PH_DATA: begin
					rem_d = rem_dec;
					if (rem_dec == '0)
						phase_d = PH_DONE;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// result of this request
	always_comb begin
		kind_d = K_HEADER;
		byte_d = 8'd0;
		last_d = 1'b0;
		if (op == OP_RESTART || !active) begin
			kind_d = K_IGNORE;
		end else if (raise) begin
			kind_d = K_ERROR;
		end else if (phase_q == PH_DATA) begin
			kind_d = K_AUDIO;
			byte_d = s_tdata;
			last_d = (rem_dec == '0);
		end else begin
			last_d = phase_q == PH_CHUNK_SIZE && pos_end4 && tag_q == TAG_DATA
				&& len_shift == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF_TAG;
			pos_q      <= '0;
			tag_q      <= '0;
			len_q      <= '0;
			rem_q      <= '0;
			fmt_seen_q <= 1'b0;
			err_q      <= E_NONE;
			fmt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= phase_d;
				pos_q      <= pos_d;
				tag_q      <= tag_d;
				len_q      <= len_d;
				rem_q      <= rem_d;
				fmt_seen_q <= fmt_seen_d;
				err_q      <= err_d;
				fmt_q      <= fmt_d;
			end
			if (s_tready)
				m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			last_q <= last_d;
		end
	end

	// state only moves on accept, so captured fields track the pending result
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {4'd0, fmt_seen_q, fmt_q[127:112], fmt_q[111:96], fmt_q[95:64],
		fmt_q[63:32], fmt_q[31:16], fmt_q[15:0], err_q, byte_q};

	a_error_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && kind_q == K_ERROR |-> err_q != E_NONE)
		else $error("error result without a held error code");

	a_audio_pcm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && kind_q == K_AUDIO |-> fmt_seen_q && fmt_q[15:0] == PCM_CODE)
		else $error("audio byte passed without a pcm format");

	a_error_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |-> err_q != E_NONE)
		else $error("error phase with no error code");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_RESTART |=> phase_q == PH_RIFF_TAG && !fmt_seen_q
			&& err_q == E_NONE)
		else $error("restart did not clear the parser");

endmodule
